FILE: rtl/sbmla_pkg.sv
// Package for the sparse block map and log allocator.
// Holds action and status codes, the controller state type and fixed field widths.
package sbmla_pkg;

    localparam int unsigned ACTION_W  = 3;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned BSIZE_W   = 21;
    localparam int unsigned ENTRIES_W = 11;
    localparam int unsigned FOFF_W    = 52;
    localparam int unsigned INDEX_W   = 16;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [VALUE_W-1:0] FREE_VALUE = '1;

    localparam logic [ACTION_W-1:0] ACT_LOOKUP    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SET       = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_RESERVE   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_TRANSLATE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_SET   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CLR_FREE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_OFF_RANGE = 3'd5;
    localparam logic [STATUS_W-1:0] ST_LIST_FULL = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_ENTRIES = 1'd1;

    typedef enum logic [3:0] {
        S_CLEAR,     // sweep map memory to free after reset
        S_IDLE,
        S_MAP_READ,  // map read data now valid
        S_RES_MUL,   // multiply block number by block size
        S_DIV,       // restoring division of log offset by block size
        S_TR_CHECK,  // range checks, list read issued
        S_TR_READ,   // list read data valid
        S_TR_MUL,    // add remainder to product of found block and block size
        S_DONE
    } t_state;

endpackage

FILE: rtl/sparse_block_map_log_allocator_top.sv
// Sparse block map with an append-only log allocator, top level.
// Uses sbmla_pkg; holds the map memory, the completed log list memory and the controller.
//
// One request at a time: start is taken while busy is low and exactly one result
// follows on o_done, which the receiver cannot stall. For lookup, set and clear the
// map memory read is issued at accept, modify and write back follow, then the result
// cycle. Reserve does one multiply of block number by block size, and an unknown
// action goes straight to the result. Translate runs a one-bit-per-cycle restoring
// divider of the log offset by the block size, then a range check, a list memory read
// and a multiply, skipping S_TR_MUL when the offset is out of range. After reset the
// block is busy while the map memory is swept to the free value; configuration
// writes are taken during that sweep and at any idle time.
module sparse_block_map_log_allocator_top #(
    parameter int unsigned MAP_ENTRIES      = 1024,
    parameter int unsigned LOG_LIST_DEPTH   = 256,
    parameter int unsigned LOG_OFFSET_WIDTH = 40
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [sbmla_pkg::ACTION_W-1:0]      i_action,
    input  logic [sbmla_pkg::INDEX_W-1:0]       i_entry_index,
    input  logic [sbmla_pkg::VALUE_W-1:0]       i_block_value,
    input  logic [sbmla_pkg::BSIZE_W-1:0]       i_message_size,
    input  logic [LOG_OFFSET_WIDTH-1:0]         i_log_offset,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sbmla_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                         i_cfg_data,
    output logic                                o_done,
    output logic [sbmla_pkg::STATUS_W-1:0]      o_status,
    output logic [sbmla_pkg::VALUE_W-1:0]       o_read_value,
    output logic [sbmla_pkg::FOFF_W-1:0]        o_file_offset
);

    localparam int unsigned MAP_AW  = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int unsigned LIST_AW = (LOG_LIST_DEPTH > 1) ? $clog2(LOG_LIST_DEPTH) : 1;
    localparam int unsigned LCNT_W  = $clog2(LOG_LIST_DEPTH + 1);
    localparam int unsigned DCNT_W  = $clog2(LOG_OFFSET_WIDTH + 1);
    localparam int unsigned VW      = sbmla_pkg::VALUE_W;
    localparam int unsigned BW      = sbmla_pkg::BSIZE_W;
    localparam int unsigned FW      = sbmla_pkg::FOFF_W;
    localparam int unsigned PW      = VW + BW;          // product width
    localparam int unsigned TW      = PW + 1;           // total width
    localparam logic [LCNT_W-1:0] LIST_FULL = LCNT_W'(LOG_LIST_DEPTH);
    localparam logic [MAP_AW-1:0] MAP_LAST  = MAP_AW'(MAP_ENTRIES - 1);

    // configuration registers
    logic [BW-1:0]                   r_block_size;
    logic [sbmla_pkg::ENTRIES_W-1:0] r_entries;

    // memories
    logic [VW-1:0] map_mem  [MAP_ENTRIES];
    logic [VW-1:0] list_mem [LOG_LIST_DEPTH];
    logic [VW-1:0] r_map_rd;
    logic [VW-1:0] r_list_rd;

    // control and allocator state
    sbmla_pkg::t_state r_state, n_state;
    logic [MAP_AW-1:0]             r_clr_addr;
    logic [VW-1:0]                 r_used;
    logic                          r_log_open;
    logic [VW-1:0]                 r_cur_block;
    logic [BW-1:0]                 r_cur_fill;
    logic [LCNT_W-1:0]             r_list_cnt;

    // request registers
    logic [sbmla_pkg::ACTION_W-1:0] r_action;
    logic [sbmla_pkg::INDEX_W-1:0]  r_index;
    logic [VW-1:0]                  r_value;
    logic [BW-1:0]                  r_msg;

    // divider
    logic [LOG_OFFSET_WIDTH-1:0] r_quot;    // shifts dividend out, quotient in
    logic [BW-1:0]               r_rem;
    logic [DCNT_W-1:0]           r_div_cnt;
    logic [BW:0]                 div_trial;

    // multiply and result
    logic [PW-1:0]                  r_prod;
    logic [sbmla_pkg::STATUS_W-1:0] r_status;
    logic [VW-1:0]                  r_rd;
    logic [FW-1:0]                  r_foff;
    logic                           r_found;

    logic [BW-1:0] bs;
    logic          accept;
    logic          idx_ok;
    logic [BW:0]   space_left;
    logic          need_new;
    logic [TW-1:0] total;
    logic          slot_hi;                 // quotient wider than list count
    logic [LCNT_W-1:0] slot;

    assign bs     = (r_block_size == '0) ? BW'(1) : r_block_size;
    assign accept = start && !busy;
    assign o_cfg_ready = (r_state == sbmla_pkg::S_CLEAR) || (r_state == sbmla_pkg::S_IDLE);

    assign idx_ok = ({1'b0, r_index} < {{(17 - sbmla_pkg::ENTRIES_W){1'b0}}, r_entries})
                 && (32'(r_index) < 32'(MAP_ENTRIES));

    assign space_left = (r_cur_fill >= bs) ? '0 : ({1'b0, bs} - {1'b0, r_cur_fill});
    assign need_new   = !r_log_open || ({1'b0, r_msg} > space_left);

    assign total = TW'(r_prod) + (r_log_open ? TW'(r_cur_fill) : TW'(0));
    assign div_trial = {r_rem, r_quot[LOG_OFFSET_WIDTH-1]};

    generate
        if (LOG_OFFSET_WIDTH > LCNT_W) begin : g_slot_wide
            assign slot_hi = |r_quot[LOG_OFFSET_WIDTH-1:LCNT_W];
            assign slot    = r_quot[LCNT_W-1:0];
        end else begin : g_slot_narrow
            assign slot_hi = 1'b0;
            assign slot    = LCNT_W'(r_quot);
        end
    endgenerate

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sbmla_pkg::S_CLEAR:    if (r_clr_addr == MAP_LAST) n_state = sbmla_pkg::S_IDLE;
            sbmla_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_action)
                        sbmla_pkg::ACT_LOOKUP,
                        sbmla_pkg::ACT_SET,
                        sbmla_pkg::ACT_CLEAR:     n_state = sbmla_pkg::S_MAP_READ;
                        sbmla_pkg::ACT_RESERVE:   n_state = sbmla_pkg::S_RES_MUL;
                        sbmla_pkg::ACT_TRANSLATE: n_state = sbmla_pkg::S_DIV;
                        default:                  n_state = sbmla_pkg::S_DONE;
                    endcase
                end
            end
            sbmla_pkg::S_MAP_READ: n_state = sbmla_pkg::S_DONE;
            sbmla_pkg::S_RES_MUL:  n_state = sbmla_pkg::S_DONE;
            sbmla_pkg::S_DIV: begin
                if (r_div_cnt == DCNT_W'(1)) n_state = sbmla_pkg::S_TR_CHECK;
            end
            sbmla_pkg::S_TR_CHECK: n_state = sbmla_pkg::S_TR_READ;
            sbmla_pkg::S_TR_READ:  n_state = r_found ? sbmla_pkg::S_TR_MUL : sbmla_pkg::S_DONE;
            sbmla_pkg::S_TR_MUL:   n_state = sbmla_pkg::S_DONE;
            sbmla_pkg::S_DONE:     n_state = sbmla_pkg::S_IDLE;
            default:               n_state = sbmla_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        busy          = (r_state != sbmla_pkg::S_IDLE);
        o_done        = (r_state == sbmla_pkg::S_DONE);
        o_status      = r_status;
        o_read_value  = r_rd;
        o_file_offset = r_foff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sbmla_pkg::S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == sbmla_pkg::S_CLEAR) r_clr_addr <= r_clr_addr + MAP_AW'(1);
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= BW'(4096);
            r_entries    <= sbmla_pkg::ENTRIES_W'(1024);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                sbmla_pkg::CFG_BLOCK_SIZE:  r_block_size <= i_cfg_data[BW-1:0];
                sbmla_pkg::CFG_MAP_ENTRIES: r_entries    <= i_cfg_data[sbmla_pkg::ENTRIES_W-1:0];
                default: ;
            endcase
        end
    end

    // map memory: sweep, read on accept, write back after modify
    always_ff @(posedge i_clk) begin
        if (r_state == sbmla_pkg::S_CLEAR) begin
            map_mem[r_clr_addr] <= sbmla_pkg::FREE_VALUE;
        end else if (r_state == sbmla_pkg::S_MAP_READ && idx_ok) begin
            if (r_action == sbmla_pkg::ACT_SET && r_map_rd == sbmla_pkg::FREE_VALUE
                && r_value != sbmla_pkg::FREE_VALUE) begin
                map_mem[r_index[MAP_AW-1:0]] <= r_value;
            end else if (r_action == sbmla_pkg::ACT_CLEAR
                         && r_map_rd != sbmla_pkg::FREE_VALUE) begin
                map_mem[r_index[MAP_AW-1:0]] <= sbmla_pkg::FREE_VALUE;
            end
        end
        if (accept) r_map_rd <= map_mem[i_entry_index[MAP_AW-1:0]];
    end

    // list memory: append on block close, read slot in translate
    always_ff @(posedge i_clk) begin
        if (r_state == sbmla_pkg::S_RES_MUL && r_msg <= bs && need_new && r_log_open
            && r_list_cnt < LIST_FULL) begin
            list_mem[r_list_cnt[LIST_AW-1:0]] <= r_cur_block;
        end
        r_list_rd <= list_mem[slot[LIST_AW-1:0]];
    end

    // allocator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_log_open  <= 1'b0;
            r_cur_block <= '0;
            r_cur_fill  <= '0;
            r_list_cnt  <= '0;
        end else if (r_state == sbmla_pkg::S_MAP_READ && idx_ok) begin
            if (r_action == sbmla_pkg::ACT_SET && r_map_rd == sbmla_pkg::FREE_VALUE
                && r_value != sbmla_pkg::FREE_VALUE) begin
                r_used <= r_used + VW'(1);
            end else if (r_action == sbmla_pkg::ACT_CLEAR
                         && r_map_rd != sbmla_pkg::FREE_VALUE) begin
                r_used <= r_used - VW'(1);
            end
        end else if (r_state == sbmla_pkg::S_RES_MUL && r_msg <= bs) begin
            if (!need_new) begin
                r_cur_fill <= r_cur_fill + r_msg;
            end else if (!(r_log_open && r_list_cnt >= LIST_FULL)) begin
                if (r_log_open) r_list_cnt <= r_list_cnt + LCNT_W'(1);
                r_cur_block <= r_used;
                r_cur_fill  <= r_msg;
                r_used      <= r_used + VW'(1);
                r_log_open  <= 1'b1;
            end
        end
    end

    // request capture, divider, multiply and result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action  <= i_action;
            r_index   <= i_entry_index;
            r_value   <= i_block_value;
            r_msg     <= i_message_size;
            r_quot    <= i_log_offset;
            r_rem     <= '0;
            r_div_cnt <= DCNT_W'(LOG_OFFSET_WIDTH);
            r_status  <= sbmla_pkg::ST_OK;
            r_rd      <= '0;
            r_foff    <= '0;
            r_found   <= 1'b0;
            // zero for a reserve or other action; list count times block size for a translate total
            if (i_action == sbmla_pkg::ACT_TRANSLATE) r_prod <= PW'(r_list_cnt) * PW'(bs);
            else r_prod <= '0;
        end
        case (r_state)
            sbmla_pkg::S_MAP_READ: begin
                if (!idx_ok) begin
                    r_status <= sbmla_pkg::ST_RANGE;
                end else if (r_action == sbmla_pkg::ACT_LOOKUP) begin
                    r_rd <= r_map_rd;
                end else if (r_action == sbmla_pkg::ACT_SET) begin
                    if (r_map_rd != sbmla_pkg::FREE_VALUE || r_value == sbmla_pkg::FREE_VALUE)
                        r_status <= sbmla_pkg::ST_BAD_SET;
                end else if (r_map_rd == sbmla_pkg::FREE_VALUE) begin
                    r_status <= sbmla_pkg::ST_CLR_FREE;
                end
            end
            sbmla_pkg::S_RES_MUL: begin
                // a fresh block has offset block*bs; an open block adds its fill
                if (r_msg > bs) begin
                    r_status <= sbmla_pkg::ST_TOO_LONG;
                end else if (need_new && r_log_open && r_list_cnt >= LIST_FULL) begin
                    r_status <= sbmla_pkg::ST_LIST_FULL;
                end else if (need_new) begin
                    r_foff <= FW'(PW'(r_used) * PW'(bs));
                end else begin
                    r_foff <= FW'(PW'(r_cur_block) * PW'(bs) + PW'(r_cur_fill));
                end
            end
            sbmla_pkg::S_DIV: begin
                // restoring step: one quotient bit per cycle
                r_div_cnt <= r_div_cnt - DCNT_W'(1);
                if (div_trial >= {1'b0, bs}) begin
                    r_rem  <= BW'(div_trial - {1'b0, bs});
                    r_quot <= {r_quot[LOG_OFFSET_WIDTH-2:0], 1'b1};
                end else begin
                    r_rem  <= div_trial[BW-1:0];
                    r_quot <= {r_quot[LOG_OFFSET_WIDTH-2:0], 1'b0};
                end
            end
            sbmla_pkg::S_TR_CHECK: begin
                // offset = quot*bs + rem, so offset <= total iff this holds
                if (!slot_hi && slot < r_list_cnt) begin
                    r_found <= 1'b1;
                end else if (!slot_hi && slot == r_list_cnt && r_log_open
                             && (TW'(r_prod) + TW'(r_rem) <= total)) begin
                    r_found <= 1'b1;
                end else begin
                    r_status <= sbmla_pkg::ST_OFF_RANGE;
                end
            end
            sbmla_pkg::S_TR_READ: begin
                if (slot < r_list_cnt) r_prod <= PW'(r_list_rd) * PW'(bs);
                else r_prod <= PW'(r_cur_block) * PW'(bs);
            end
            sbmla_pkg::S_TR_MUL: begin
                r_foff <= FW'(r_prod + PW'(r_rem));
            end
            default: ;
        endcase
    end

    // checks
    a_done_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result shown while idle");
    a_list_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_list_cnt <= LIST_FULL)
        else $error("list count beyond depth");
    a_ok_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != sbmla_pkg::ST_OK) |-> (o_file_offset == '0 && o_read_value == '0))
        else $error("fields set on error status");

endmodule
